// File: rtl/sme_pkg.sv
package sme_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int HEAP_WORDS = 1024;
	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int HA_W = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;

	typedef enum logic [4:0] {
		OP_PUSH = 5'd0, OP_POP = 5'd1, OP_ADD = 5'd2, OP_SUB = 5'd3, OP_MUL = 5'd4,
		OP_DIV = 5'd5, OP_MOD = 5'd6, OP_POW = 5'd7, OP_NEG = 5'd8, OP_FACT = 5'd9,
		OP_NOP = 5'd10, OP_PRINT = 5'd11, OP_DUP = 5'd12, OP_JMP = 5'd13,
		OP_JZ = 5'd14, OP_JNZ = 5'd15, OP_JE = 5'd16, OP_JNE = 5'd17, OP_JG = 5'd18,
		OP_JGE = 5'd19, OP_JL = 5'd20, OP_JLE = 5'd21, OP_GT = 5'd22, OP_LT = 5'd23,
		OP_STORE = 5'd24, OP_LOAD = 5'd25, OP_SYSCALL = 5'd26, OP_HALT = 5'd27,
		OP_BAD0 = 5'd28, OP_BAD1 = 5'd29, OP_BAD2 = 5'd30, OP_BAD3 = 5'd31
	} op_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0, ST_HALT = 4'd1, ST_OVF = 4'd2, ST_UNF = 4'd3, ST_DIV0 = 4'd4,
		ST_MOD0 = 4'd5, ST_FNEG = 4'd6, ST_BADADDR = 4'd7, ST_BADOP = 4'd8,
		ST_BADCALL = 4'd9, ST_STOPPED = 4'd10
	} status_t;

	typedef enum logic [1:0] {
		AU_MUL = 2'd0, AU_DIV = 2'd1, AU_POW = 2'd2, AU_FACT = 2'd3
	} au_op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD1, S_RD2, S_HEAP, S_EXEC, S_WAIT, S_WB, S_OUT
	} state_t;

	typedef struct packed {
		logic   start;
		au_op_t op;
	} au_req_t;

endpackage

// File: rtl/sme_ram.sv
module sme_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/sme_arith.sv
module sme_arith import sme_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  au_req_t     req,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] result,
	output logic [63:0] quotient,
	output logic [63:0] remainder
);

	// Multiplier is 32x32 partial products, one per cycle, accumulated.
	logic        busy_q, mbusy_q;
	au_op_t      op_q;
	logic [6:0]  cnt_q;
	logic [1:0]  pp_q;
	logic [63:0] x_q, y_q, acc_q, rem_q, quo_q, ma_q, mb_q, mp_q, base_q, ex_q;
	logic [63:0] pp_prod;
	logic [31:0] pa, pb;
	logic [64:0] rtry;
	logic        mdone;
	logic [1:0]  phase_q;

	always_comb begin
		pa = pp_q[0] ? ma_q[63:32] : ma_q[31:0];
		pb = pp_q[1] ? mb_q[63:32] : mb_q[31:0];
		pp_prod = {32'd0, pa} * {32'd0, pb};
	end

	assign rtry = {rem_q, x_q[63]} - {1'b0, y_q};
	assign mdone = mbusy_q && (pp_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mbusy_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				x_q <= a;
				y_q <= b;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
				phase_q <= 2'd0;
				acc_q <= 64'd1;
				base_q <= a;
				ex_q <= b;
				mbusy_q <= 1'b0;
			end else if (busy_q) begin
				if (mbusy_q) begin
					// products 0x0, 1x0, 0x1 contribute to low 64 bits
					case (pp_q)
						2'd0: mp_q <= pp_prod;
						2'd1: mp_q <= mp_q + {pp_prod[31:0], 32'd0};
						default: mp_q <= mp_q + {pp_prod[31:0], 32'd0};
					endcase
					pp_q <= (pp_q == 2'd0) ? 2'd1 : 2'd2;
					if (mdone)
						mbusy_q <= 1'b0;
				end else begin
					case (op_q)
						AU_MUL: begin
							if (phase_q == 2'd0) begin
								ma_q <= x_q; mb_q <= y_q; pp_q <= 2'd0;
								mbusy_q <= 1'b1; phase_q <= 2'd1;
							end else begin
								result <= mp_q; done <= 1'b1; busy_q <= 1'b0;
							end
						end
						AU_DIV: begin
							if (rtry[64]) begin
								rem_q <= {rem_q[62:0], x_q[63]};
								quo_q <= {quo_q[62:0], 1'b0};
							end else begin
								rem_q <= rtry[63:0];
								quo_q <= {quo_q[62:0], 1'b1};
							end
							x_q <= {x_q[62:0], 1'b0};
							cnt_q <= cnt_q + 7'd1;
							if (cnt_q == 7'd63)
								busy_q <= 1'b0;
							done <= (cnt_q == 7'd63);
						end
						AU_POW: begin
							// phase 0: decide; 1: acc*base pending; 2: base*base pending
							case (phase_q)
								2'd0: begin
									if (ex_q == 64'd0) begin
										result <= acc_q; done <= 1'b1; busy_q <= 1'b0;
									end else if (ex_q[0]) begin
										ma_q <= acc_q; mb_q <= base_q; pp_q <= 2'd0;
										mbusy_q <= 1'b1; phase_q <= 2'd1;
									end else begin
										ma_q <= base_q; mb_q <= base_q; pp_q <= 2'd0;
										mbusy_q <= 1'b1; phase_q <= 2'd2;
									end
								end
								2'd1: begin
									acc_q <= mp_q;
									ma_q <= base_q; mb_q <= base_q; pp_q <= 2'd0;
									mbusy_q <= 1'b1; phase_q <= 2'd2;
								end
								default: begin
									base_q <= mp_q;
									ex_q <= {1'b0, ex_q[63:1]};
									phase_q <= 2'd0;
								end
							endcase
						end
						default: begin
							// factorial: acc *= i for i = 2..n
							if (phase_q == 2'd0) begin
								if (x_q >= 64'd66) begin
									result <= '0; done <= 1'b1; busy_q <= 1'b0;
								end else begin
									base_q <= 64'd2; phase_q <= 2'd1;
								end
							end else if (phase_q == 2'd1) begin
								if (base_q > x_q) begin
									result <= acc_q; done <= 1'b1; busy_q <= 1'b0;
								end else begin
									ma_q <= acc_q; mb_q <= base_q; pp_q <= 2'd0;
									mbusy_q <= 1'b1; phase_q <= 2'd2;
								end
							end else begin
								acc_q <= mp_q;
								base_q <= base_q + 64'd1;
								phase_q <= 2'd1;
							end
						end
					endcase
				end
			end
		end
	end

	// Quotient and remainder are final in the cycle in which done is high.
	assign quotient = quo_q;
	assign remainder = rem_q;

	property p_idle_no_done;
		@(posedge clk) disable iff (!arst_n) (!busy_q && !req.start) |=> !done || $past(busy_q);
	endproperty
	a_idle_no_done: assert property (p_idle_no_done) else $error("done without work");
	a_mul_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		mbusy_q |-> pp_q != 2'd3) else $error("bad partial product index");
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q) else $error("start did not arm");

endmodule

// File: rtl/stack_machine_execute_core.sv
// Execute unit of a 64-bit stack machine.
// Input channel (cmd, immediate) and result channel (status, branch
// fields, print fields) both transfer on valid and ready high together.
// The configuration register exit_call_id is written by cfg_we/cfg_wdata;
// the user must write it only while the unit is idle; the unit does not enforce this.
// The operand stack and the heap each live in a single-port-write,
// one-read synchronous RAM. An instruction reads up to two stack words
// in turn, then executes and writes back at most one word.
// After the input transfer the core reads the top of stack (RD1), then
// the second word for two-operand ops (RD2) or the heap word for load
// (HEAP), and executes (EXEC). Error-free mul, div, mod, power and
// factorial then wait (WAIT) on the shared iterative arithmetic unit and
// write back (WB). The result is registered; the core returns via OUT to IDLE.
// One instruction is in flight at a time; the next transfer is taken when
// the result register is empty or being drained in the same cycle.
// Reset empties the stack, clears the stop flag and sets exit_call_id to
// zero; RAM contents are not cleared. When the receiver stalls, the
// finished result waits in the output register and no new item is taken.
// After any error or halt every item returns the stopped status.
module stack_machine_execute_core import sme_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  cmd,
	input  logic [63:0] immediate,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic        branch_taken,
	output logic signed [63:0] branch_offset,
	output logic        print_valid,
	output logic [63:0] print_value
);

	state_t state_q, state_d;
	logic [7:0] exit_id_q;
	logic [CNT_W-1:0] cnt_q;
	logic stopped_q;
	op_t op_q;
	logic [63:0] imm_q, r_q, l_q;
	logic [63:0] res_d;
	logic [63:0] wb_val_q;

	// stack RAM
	logic s_we;
	logic [SP_W-1:0] s_waddr, s_raddr;
	logic [63:0] s_wdata, s_rdata;
	sme_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH), .AW(SP_W)) u_stack (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata));

	logic h_we;
	logic [HA_W-1:0] h_addr;
	logic [63:0] h_rdata;
	sme_ram #(.WIDTH(64), .DEPTH(HEAP_WORDS), .AW(HA_W)) u_heap (
		.clk(clk), .we(h_we), .waddr(h_addr), .wdata(r_q),
		.raddr(h_addr), .rdata(h_rdata));

	// Factorial works on the top of stack, the binary operators on both.
	au_req_t au_req;
	logic au_done;
	logic [63:0] au_res, au_quo, au_rem, au_a;
	assign au_a = (op_q == OP_FACT) ? r_q : l_q;
	sme_arith u_arith (
		.clk(clk), .arst_n(arst_n), .req(au_req), .a(au_a), .b(r_q),
		.done(au_done), .result(au_res), .quotient(au_quo), .remainder(au_rem));

	// Classification of the accepted opcode.
	logic need1, need2, is_jcc2, heap_ok, is_exit;
	always_comb begin
		need2 = (op_q inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW,
			OP_GT, OP_LT, OP_JE, OP_JNE, OP_JG, OP_JGE, OP_JL, OP_JLE});
		need1 = need2 || (op_q inside {OP_POP, OP_NEG, OP_FACT, OP_PRINT, OP_DUP,
			OP_JZ, OP_JNZ, OP_STORE, OP_SYSCALL});
		is_jcc2 = (op_q inside {OP_JE, OP_JNE, OP_JG, OP_JGE, OP_JL, OP_JLE});
		heap_ok = (imm_q < 64'(HEAP_WORDS));
		is_exit = (r_q[31:0] == {24'd0, exit_id_q});
	end

	logic cond;
	always_comb begin
		case (op_q)
			OP_JE:  cond = (l_q == r_q);
			OP_JNE: cond = (l_q != r_q);
			OP_JG:  cond = (l_q > r_q);
			OP_JGE: cond = (l_q >= r_q);
			OP_JL:  cond = (l_q < r_q);
			OP_JLE: cond = (l_q <= r_q);
			OP_JZ:  cond = (r_q == 64'd0);
			OP_JNZ: cond = (r_q != 64'd0);
			default: cond = 1'b1;
		endcase
	end

	logic out_free;
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;

	// result-forming signals
	logic o_load;
	status_t o_st;
	logic o_tk, o_pv;
	logic [63:0] o_off, o_pval;
	logic [CNT_W-1:0] cnt_d;
	logic stop_set;

	always_comb begin
		state_d = state_q;
		s_we = 1'b0;
		s_waddr = SP_W'(cnt_q - CNT_W'(1));
		s_wdata = wb_val_q;
		s_raddr = SP_W'(cnt_q - CNT_W'(1));
		h_we = 1'b0;
		h_addr = imm_q[HA_W-1:0];
		au_req = '{start: 1'b0, op: AU_MUL};
		o_load = 1'b0; o_st = ST_OK; o_tk = 1'b0; o_pv = 1'b0;
		o_off = '0; o_pval = '0;
		cnt_d = cnt_q;
		stop_set = 1'b0;
		res_d = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready)
					state_d = S_RD1;
			end
			S_RD1: begin
				// The top of stack arrives now; the second word is asked for here.
				s_raddr = need2 ? SP_W'(cnt_q - CNT_W'(2)) : SP_W'(cnt_q - CNT_W'(1));
				if (stopped_q || op_q inside {OP_BAD0, OP_BAD1, OP_BAD2, OP_BAD3}
						|| !need1 || cnt_q == '0)
					state_d = S_EXEC;
				else
					state_d = need2 ? S_RD2 : S_EXEC;
				if (!stopped_q && op_q == OP_LOAD)
					state_d = S_HEAP;
			end
			S_RD2: state_d = S_EXEC;
			S_HEAP: state_d = S_EXEC;
			S_EXEC: begin
				state_d = S_OUT;
				o_load = 1'b1;
				if (stopped_q) o_st = ST_STOPPED;
				else if (op_q inside {OP_BAD0, OP_BAD1, OP_BAD2, OP_BAD3}) begin
					o_st = ST_BADOP; stop_set = 1'b1;
				end else begin
					case (op_q)
						OP_PUSH: begin
							if (cnt_q == CNT_W'(STACK_DEPTH)) o_st = ST_OVF;
							else begin
								s_we = 1'b1; s_waddr = SP_W'(cnt_q); s_wdata = imm_q;
								cnt_d = cnt_q + CNT_W'(1);
							end
						end
						OP_NOP: ;
						OP_JMP: begin o_tk = 1'b1; o_off = imm_q; end
						OP_HALT: o_st = ST_HALT;
						OP_LOAD: begin
							if (!heap_ok) o_st = ST_BADADDR;
							else if (cnt_q == CNT_W'(STACK_DEPTH)) o_st = ST_OVF;
							else begin
								s_we = 1'b1; s_waddr = SP_W'(cnt_q); s_wdata = h_rdata;
								cnt_d = cnt_q + CNT_W'(1);
							end
						end
						default: begin
							if (cnt_q == '0) o_st = ST_UNF;
							else if (need2 && cnt_q < CNT_W'(2)) o_st = ST_UNF;
							else begin
								case (op_q)
									OP_POP: cnt_d = cnt_q - CNT_W'(1);
									OP_NEG: begin s_we = 1'b1; s_wdata = 64'd0 - r_q; end
									OP_FACT: begin
										if (r_q[63]) o_st = ST_FNEG;
										else begin
											au_req = '{start: 1'b1, op: AU_FACT};
											o_load = 1'b0; state_d = S_WAIT;
										end
									end
									OP_PRINT: begin
										cnt_d = cnt_q - CNT_W'(1); o_pv = 1'b1; o_pval = r_q;
									end
									OP_DUP: begin
										if (cnt_q == CNT_W'(STACK_DEPTH)) o_st = ST_OVF;
										else begin
											s_we = 1'b1; s_waddr = SP_W'(cnt_q); s_wdata = r_q;
											cnt_d = cnt_q + CNT_W'(1);
										end
									end
									OP_JZ, OP_JNZ: begin
										cnt_d = cnt_q - CNT_W'(1);
										o_tk = cond; o_off = cond ? imm_q : 64'd0;
									end
									OP_STORE: begin
										if (!heap_ok) o_st = ST_BADADDR;
										else begin h_we = 1'b1; cnt_d = cnt_q - CNT_W'(1); end
									end
									OP_SYSCALL: begin
										if (is_exit) begin
											if (cnt_q < CNT_W'(2)) o_st = ST_UNF;
											else begin cnt_d = cnt_q - CNT_W'(2); o_st = ST_HALT; end
										end else begin
											cnt_d = cnt_q - CNT_W'(1); o_st = ST_BADCALL;
										end
									end
									default: begin
										if (is_jcc2) begin
											cnt_d = cnt_q - CNT_W'(2);
											o_tk = cond; o_off = cond ? imm_q : 64'd0;
										end else begin
											s_waddr = SP_W'(cnt_q - CNT_W'(2));
											case (op_q)
												OP_ADD: res_d = l_q + r_q;
												OP_SUB: res_d = l_q - r_q;
												OP_GT: res_d = {63'd0, l_q > r_q};
												OP_LT: res_d = {63'd0, l_q < r_q};
												default: res_d = '0;
											endcase
											s_wdata = res_d;
											if (op_q == OP_DIV && r_q == '0) o_st = ST_DIV0;
											else if (op_q == OP_MOD && r_q == '0) o_st = ST_MOD0;
											else if (op_q inside {OP_MUL, OP_DIV, OP_MOD, OP_POW}) begin
												case (op_q)
													OP_MUL: au_req = '{start: 1'b1, op: AU_MUL};
													OP_POW: au_req = '{start: 1'b1, op: AU_POW};
													default: au_req = '{start: 1'b1, op: AU_DIV};
												endcase
												o_load = 1'b0; state_d = S_WAIT;
											end else begin
												s_we = 1'b1; cnt_d = cnt_q - CNT_W'(1);
											end
										end
									end
								endcase
							end
						end
					endcase
					if (o_st != ST_OK) begin
						stop_set = 1'b1; s_we = 1'b0; h_we = 1'b0; cnt_d = cnt_q;
						o_tk = 1'b0; o_off = '0; o_pv = 1'b0; o_pval = '0;
					end
				end
			end
			S_WAIT: begin
				if (au_done)
					state_d = S_WB;
			end
			S_WB: begin
				// Write the result of the arithmetic unit back to the stack.
				o_load = 1'b1;
				state_d = S_OUT;
				s_we = 1'b1;
				if (op_q == OP_FACT) begin
					s_waddr = SP_W'(cnt_q - CNT_W'(1)); s_wdata = wb_val_q;
				end else begin
					s_waddr = SP_W'(cnt_q - CNT_W'(2)); s_wdata = wb_val_q;
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exit_id_q <= '0;
			cnt_q <= '0;
			stopped_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we)
				exit_id_q <= cfg_wdata;
			cnt_q <= cnt_d;
			if (stop_set || (o_load && o_st == ST_HALT))
				stopped_q <= 1'b1;
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			if (o_load)
				out_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= op_t'(cmd);
			imm_q <= immediate;
		end
		if (state_q == S_RD1)
			r_q <= s_rdata;
		if (state_q == S_RD2)
			l_q <= s_rdata;
		if (state_q == S_WAIT && au_done)
			wb_val_q <= (op_q == OP_DIV) ? au_quo : ((op_q == OP_MOD) ? au_rem : au_res);
		if (o_load) begin
			status <= o_st;
			branch_taken <= o_tk;
			branch_offset <= o_off;
			print_valid <= o_pv;
			print_value <= o_pval;
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("second item taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)
		&& $stable(branch_offset) && $stable(print_value)))
		else $error("result changed while waiting");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH)) else $error("stack count out of range");

endmodule
